// File: hw/rtl/eart_pkg.sv
// ----------------------------------------------------------------------------
// Euler angle rate transform package
// Shared constants for the angle front end, the rotation CORDIC and the
// stream widths of the Euler angle rate transform.
// ----------------------------------------------------------------------------
package eart_pkg;

	localparam int ANGLE_FRAC_BITS = 7;
	localparam int ANGLE_W = 16;
	localparam int RATE_W = 32;

	localparam longint HALF = 180 * (longint'(1) << ANGLE_FRAC_BITS);
	localparam longint QUARTER = HALF / 2;
	localparam int WRAP_W = $clog2(2 * HALF) + 2;
	localparam int MAG_W = $clog2(QUARTER + 1);

	localparam longint PI_Q30 = 64'd3373259426;
	localparam longint PI_QUO = PI_Q30 / HALF;
	localparam longint PI_REM = PI_Q30 % HALF;
	localparam int QUO_W = $clog2(PI_QUO + 1);
	localparam int NUM_W = $clog2(QUARTER * HALF + HALF);
	localparam int Y_SHIFT = ANGLE_FRAC_BITS + 2;
	localparam int Y_W = NUM_W - Y_SHIFT;
	localparam int REC_SH = Y_W + 6;
	localparam longint RECIP = ((longint'(1) << REC_SH) + 44) / 45;
	localparam int REC_W = $clog2(RECIP + 1);
	localparam int RAD_W = 32;

	localparam int STEPS = 24;
	localparam int XY_W = 34;
	localparam int Z_W = 33;
	localparam longint GAIN_Q30 = 652032874;
	localparam int CORDIC_LAT = STEPS + 3;

	localparam logic signed [Z_W-1:0] ATAN_Q30 [STEPS] = '{
		33'sd843314856, 33'sd497837829, 33'sd263043836, 33'sd133525158,
		33'sd67021686, 33'sd33543515, 33'sd16775850, 33'sd8388437,
		33'sd4194282, 33'sd2097149, 33'sd1048575, 33'sd524287,
		33'sd262143, 33'sd131071, 33'sd65535, 33'sd32767,
		33'sd16383, 33'sd8191, 33'sd4095, 33'sd2047,
		33'sd1023, 33'sd511, 33'sd255, 33'sd127
	};

	localparam int DIV_BITS = 35;
	localparam int DEN_W = 31;
	localparam logic [DIV_BITS-1:0] QUOT_CAP = DIV_BITS'(longint'(1) << (DIV_BITS - 1));

	localparam int IN_TDATA_W = 128;
	localparam int OUT_TDATA_W = 96;

endpackage

// File: hw/rtl/eart_cordic.sv
// ----------------------------------------------------------------------------
// Pipelined sine and cosine of an angle in degrees
// Wraps and mirrors the angle into the right half plane, scales it to radians
// and runs one rotation CORDIC step per pipeline stage.
// ----------------------------------------------------------------------------
module eart_cordic (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [eart_pkg::ANGLE_W-1:0]   angle,
	output logic signed [eart_pkg::RATE_W-1:0]    sin_val,
	output logic signed [eart_pkg::RATE_W-1:0]    cos_val
);

	localparam int W = eart_pkg::WRAP_W;
	localparam int N = eart_pkg::STEPS;
	localparam int PW = eart_pkg::Y_W + eart_pkg::REC_W;

	logic signed [W-1:0] a_ext, a_wrap, a_mir;
	logic                a_flip;

	logic [eart_pkg::MAG_W-1:0]               mag_s1;
	logic                                     neg_s1, nc_s1;
	logic [eart_pkg::QUO_W+eart_pkg::MAG_W-1:0] quo_s2;
	logic [eart_pkg::Y_W-1:0]                 y_s2;
	logic                                     neg_s2, nc_s2;

	logic [eart_pkg::NUM_W-1:0]   num;
	logic [PW-1:0]                prod, frac;
	logic [eart_pkg::RAD_W-1:0]   rad;
	logic signed [eart_pkg::Z_W-1:0] z_init;

	logic signed [eart_pkg::XY_W-1:0] x_s [N+1];
	logic signed [eart_pkg::XY_W-1:0] y_s [N+1];
	logic signed [eart_pkg::Z_W-1:0]  z_s [N+1];
	logic                             nc_s [N+1];

	always_comb begin
		a_ext = W'(angle);
		if (a_ext >= W'(eart_pkg::HALF)) begin
			a_wrap = a_ext - W'(2 * eart_pkg::HALF);
		end else if (a_ext < -W'(eart_pkg::HALF)) begin
			a_wrap = a_ext + W'(2 * eart_pkg::HALF);
		end else begin
			a_wrap = a_ext;
		end
		if (a_wrap > W'(eart_pkg::QUARTER)) begin
			a_mir = W'(eart_pkg::HALF) - a_wrap;
			a_flip = 1'b1;
		end else if (a_wrap < -W'(eart_pkg::QUARTER)) begin
			a_mir = -W'(eart_pkg::HALF) - a_wrap;
			a_flip = 1'b1;
		end else begin
			a_mir = a_wrap;
			a_flip = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= eart_pkg::MAG_W'(a_mir[W-1] ? -a_mir : a_mir);
			neg_s1 <= a_mir[W-1];
			nc_s1 <= a_flip;
		end
	end

	// Radians split as whole and fractional parts of the scale factor.
	assign num = eart_pkg::NUM_W'(mag_s1) * eart_pkg::NUM_W'(eart_pkg::PI_REM)
		+ eart_pkg::NUM_W'(eart_pkg::HALF / 2);

	always_ff @(posedge clk) begin
		if (en) begin
			quo_s2 <= mag_s1 * eart_pkg::QUO_W'(eart_pkg::PI_QUO);
			y_s2 <= num[eart_pkg::NUM_W-1:eart_pkg::Y_SHIFT];
			neg_s2 <= neg_s1;
			nc_s2 <= nc_s1;
		end
	end

	assign prod = y_s2 * eart_pkg::REC_W'(eart_pkg::RECIP);
	assign frac = prod >> eart_pkg::REC_SH;
	assign rad = eart_pkg::RAD_W'(quo_s2) + eart_pkg::RAD_W'(frac);
	assign z_init = neg_s2 ? -eart_pkg::Z_W'(rad) : eart_pkg::Z_W'(rad);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= eart_pkg::XY_W'(eart_pkg::GAIN_Q30);
			y_s[0] <= '0;
			z_s[0] <= z_init;
			nc_s[0] <= nc_s2;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][eart_pkg::Z_W-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - eart_pkg::ATAN_Q30[i];
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + eart_pkg::ATAN_Q30[i];
				end
				nc_s[i+1] <= nc_s[i];
			end
		end
	end

	assign cos_val = eart_pkg::RATE_W'(nc_s[N] ? -x_s[N] : x_s[N]);
	assign sin_val = eart_pkg::RATE_W'(y_s[N]);

endmodule

// File: hw/rtl/euler_angle_rate_transform.sv
// ----------------------------------------------------------------------------
// Euler angle rate transform
// Turns body angular rates and pitch and roll angles into heading, pitch and
// roll angle rates, saturating results that leave the 32-bit range.
//
// The slave channel carries one attitude sample per transaction: the three
// body rates and the pitch and roll angles in s_tdata. The master channel
// returns one transaction per sample, the three Euler rates in m_tdata and
// the saturation flag in m_tuser. Results leave in the order samples came.
// An accepted sample passes the angle scaling and 24-step CORDIC, the
// products and operand preparation, the bit-per-stage dividers, rounding
// and clipping and the output register on its way to m_tvalid. One sample
// is taken per cycle while s_tready is high. When the receiver stalls, the
// output register holds its result and a skid register takes the next one;
// the pipeline then halts as a whole and s_tready falls until the skid
// register drains. Reset empties the pipeline and both output registers;
// the block keeps no other state.
// ----------------------------------------------------------------------------
module euler_angle_rate_transform (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// body_rate_z, body_rate_y, body_rate_x, pitch_deg, roll_deg
	input  logic [eart_pkg::IN_TDATA_W-1:0]       s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// heading_rate, pitch_rate, roll_rate
	output logic [eart_pkg::OUT_TDATA_W-1:0]      m_tdata,
	// saturated
	output logic [0:0]                            m_tuser
);

	localparam int CL = eart_pkg::CORDIC_LAT;
	localparam int DB = eart_pkg::DIV_BITS;
	localparam int DW = eart_pkg::DEN_W;
	localparam int LAT = CL + 5 + DB;

	typedef struct packed {
		logic signed [31:0] wz;
		logic signed [31:0] wy;
		logic signed [31:0] wx;
	} rates_t;

	typedef struct packed {
		logic [DW-1:0] rem;
		logic [DB-1:0] nlo;
		logic [DB-1:0] quo;
	} div_t;

	typedef struct packed {
		logic [DW-1:0]      den;
		logic               neg_h;
		logic               neg_t;
		logic               ovf_h;
		logic               ovf_t;
		logic               zero_h;
		logic               zero_t;
		logic [31:0]        pr;
		logic               fp;
		logic signed [31:0] wx;
	} side_t;

	typedef struct packed {
		logic        sat;
		logic [31:0] val;
	} clip_t;

	typedef struct packed {
		logic [31:0] h;
		logic [31:0] p;
		logic [31:0] r;
		logic        sat;
	} res_t;

	function automatic clip_t clip_rate(input logic signed [36:0] v);
		clip_t c;
		if (v > 37'sd2147483647) begin
			c.sat = 1'b1;
			c.val = 32'h7fff_ffff;
		end else if (v < -37'sd2147483648) begin
			c.sat = 1'b1;
			c.val = 32'h8000_0000;
		end else begin
			c.sat = 1'b0;
			c.val = v[31:0];
		end
		return c;
	endfunction

	function automatic div_t div_step(input div_t d, input logic [DW-1:0] den);
		logic [DW:0] t;
		logic        ge;
		div_t        n;
		t = {d.rem, d.nlo[DB-1]};
		ge = t >= {1'b0, den};
		n.rem = ge ? DW'(t - {1'b0, den}) : t[DW-1:0];
		n.nlo = d.nlo << 1;
		n.quo = {d.quo[DB-2:0], ge};
		return n;
	endfunction

	logic           en;
	logic [LAT-1:0] vld_s;
	rates_t         rates_in;
	rates_t         rates_s [CL];

	logic signed [31:0] sin_p, cos_p, sin_r, cos_r;

	logic signed [63:0] pzc_s1, pys_s1, pzs_s1, pyc_s1;
	logic signed [31:0] sp_s1, cp_s1, wx_s1;

	logic signed [64:0] sum_a, sum_p;
	clip_t              clip_p;
	logic signed [34:0] ar_s2;
	logic [31:0]        pr_s2;
	logic               fp_s2;
	logic signed [31:0] sp_s2, cp_s2, wx_s2;

	logic               ar_neg;
	logic signed [34:0] ar_abs;
	logic [32:0]        ar_mag;
	logic [31:0]        sp_mag, cp_mag;
	logic [64:0]        prod_t;
	logic [63:0]        num_h_s3, num_t_s3;
	logic [DW-1:0]      den_s3;
	logic               neg_h_s3, neg_t_s3;
	logic [31:0]        pr_s3;
	logic               fp_s3;
	logic signed [31:0] wx_s3;

	div_t  dh_s [DB+1];
	div_t  dt_s [DB+1];
	side_t side_s [DB+1];

	logic [DB-1:0]        qh, qt;
	logic signed [DB:0]   hs, ts;
	logic signed [36:0]   rr;
	clip_t                clip_h, clip_r;
	res_t                 tail_s, out_q, skid_q;
	logic                 out_v_q, skid_v_q;

	assign en = !skid_v_q;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], s_tvalid};
		end
	end

	assign rates_in.wz = s_tdata[31:0];
	assign rates_in.wy = s_tdata[63:32];
	assign rates_in.wx = s_tdata[95:64];

	always_ff @(posedge clk) begin
		if (en) begin
			rates_s[0] <= rates_in;
			for (int i = 1; i < CL; i++) begin
				rates_s[i] <= rates_s[i-1];
			end
		end
	end

	eart_cordic u_pitch (
		.clk     (clk),
		.en      (en),
		.angle   (s_tdata[111:96]),
		.sin_val (sin_p),
		.cos_val (cos_p)
	);

	eart_cordic u_roll (
		.clk     (clk),
		.en      (en),
		.angle   (s_tdata[127:112]),
		.sin_val (sin_r),
		.cos_val (cos_r)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			pzc_s1 <= rates_s[CL-1].wz * cos_r;
			pys_s1 <= rates_s[CL-1].wy * sin_r;
			pzs_s1 <= rates_s[CL-1].wz * sin_r;
			pyc_s1 <= rates_s[CL-1].wy * cos_r;
			sp_s1 <= sin_p;
			cp_s1 <= cos_p;
			wx_s1 <= rates_s[CL-1].wx;
		end
	end

	assign sum_a = 65'(pzc_s1) - 65'(pys_s1) + (65'sd1 <<< 29);
	assign sum_p = 65'(pzs_s1) + 65'(pyc_s1) + (65'sd1 <<< 29);
	assign clip_p = clip_rate(37'($signed(sum_p[64:30])));

	always_ff @(posedge clk) begin
		if (en) begin
			ar_s2 <= sum_a[64:30];
			pr_s2 <= clip_p.val;
			fp_s2 <= clip_p.sat;
			sp_s2 <= sp_s1;
			cp_s2 <= cp_s1;
			wx_s2 <= wx_s1;
		end
	end

	assign ar_neg = ar_s2[34];
	assign ar_abs = ar_neg ? -ar_s2 : ar_s2;
	assign ar_mag = ar_abs[32:0];
	assign sp_mag = sp_s2[31] ? 32'(-sp_s2) : 32'(sp_s2);
	assign cp_mag = cp_s2[31] ? 32'(-cp_s2) : 32'(cp_s2);
	assign prod_t = ar_mag * sp_mag;

	always_ff @(posedge clk) begin
		if (en) begin
			num_h_s3 <= {1'b0, ar_mag, 30'b0};
			num_t_s3 <= prod_t[63:0];
			den_s3 <= cp_mag[DW-1:0];
			neg_h_s3 <= ar_neg ^ cp_s2[31];
			neg_t_s3 <= ar_neg ^ sp_s2[31] ^ cp_s2[31];
			pr_s3 <= pr_s2;
			fp_s3 <= fp_s2;
			wx_s3 <= wx_s2;
		end
	end

	// A quotient of 2^35 or more is caught before the division starts.
	always_ff @(posedge clk) begin
		if (en) begin
			dh_s[0].rem <= DW'(num_h_s3[63:DB]);
			dh_s[0].nlo <= num_h_s3[DB-1:0];
			dh_s[0].quo <= '0;
			dt_s[0].rem <= DW'(num_t_s3[63:DB]);
			dt_s[0].nlo <= num_t_s3[DB-1:0];
			dt_s[0].quo <= '0;
			side_s[0].den <= den_s3;
			side_s[0].neg_h <= neg_h_s3;
			side_s[0].neg_t <= neg_t_s3;
			side_s[0].ovf_h <= DW'(num_h_s3[63:DB]) >= den_s3;
			side_s[0].ovf_t <= DW'(num_t_s3[63:DB]) >= den_s3;
			side_s[0].zero_h <= num_h_s3 == '0;
			side_s[0].zero_t <= num_t_s3 == '0;
			side_s[0].pr <= pr_s3;
			side_s[0].fp <= fp_s3;
			side_s[0].wx <= wx_s3;
		end
	end

	for (genvar k = 0; k < DB; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (en) begin
				dh_s[k+1] <= div_step(dh_s[k], side_s[k].den);
				dt_s[k+1] <= div_step(dt_s[k], side_s[k].den);
				side_s[k+1] <= side_s[k];
			end
		end
	end

	always_comb begin
		if (side_s[DB].zero_h) begin
			qh = '0;
		end else if (side_s[DB].ovf_h || dh_s[DB].quo > eart_pkg::QUOT_CAP) begin
			qh = eart_pkg::QUOT_CAP;
		end else begin
			qh = dh_s[DB].quo;
		end
		if (side_s[DB].zero_t) begin
			qt = '0;
		end else if (side_s[DB].ovf_t || dt_s[DB].quo > eart_pkg::QUOT_CAP) begin
			qt = eart_pkg::QUOT_CAP;
		end else begin
			qt = dt_s[DB].quo;
		end
		hs = side_s[DB].neg_h ? -$signed({1'b0, qh}) : $signed({1'b0, qh});
		ts = side_s[DB].neg_t ? -$signed({1'b0, qt}) : $signed({1'b0, qt});
		rr = 37'(side_s[DB].wx) - 37'(ts);
		clip_h = clip_rate(37'(hs));
		clip_r = clip_rate(rr);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tail_s.h <= clip_h.val;
			tail_s.p <= side_s[DB].pr;
			tail_s.r <= clip_r.val;
			tail_s.sat <= clip_h.sat | clip_r.sat | side_s[DB].fp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			if (skid_v_q) begin
				out_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= vld_s[LAT-1];
			end
		end else if (vld_s[LAT-1] && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			out_q <= skid_v_q ? skid_q : tail_s;
		end
		if (out_v_q && !m_tready && !skid_v_q) begin
			skid_q <= tail_s;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {out_q.r, out_q.p, out_q.h};
	assign m_tuser = out_q.sat;

`ifndef SYNTH
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register holds a result while the output register is empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !m_tready))
		else $error("skid register filled without a stalled output");

	a_pipe_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |=> $stable(vld_s))
		else $error("pipeline valid bits moved while the pipeline was halted");
`endif

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Euler angle rate transform testbench
// Drives attitude samples with random gaps and a receiver that stalls at
// random. A bit-exact model of the angle scaling, the CORDIC and the capped
// division predicts each result, and every output transaction is checked
// field by field, in order, against it.
// ----------------------------------------------------------------------------
module tb;

	typedef struct {
		logic signed [31:0] wz, wy, wx;
		logic signed [15:0] pitch, roll;
	} sample_t;

	typedef struct {
		logic signed [31:0] heading, pitch, roll;
		logic               sat;
	} rates_t;

	localparam longint CAP = longint'(1) << 34;
	localparam longint ATAN [24] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287,
		262143, 131071, 65535, 32767, 16383, 8191,
		4095, 2047, 1023, 511, 255, 127
	};

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [eart_pkg::IN_TDATA_W-1:0] s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [eart_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic [0:0]            m_tuser;

	rates_t pending_rates[$];
	int     errors;
	int     samples_sent;
	int     results_seen;
	int     sat_seen;
	bit     rx_always_ready;

	euler_angle_rate_transform uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void angle_sin_cos(input longint a, output longint s,
			output longint c);
		longint r, rad, x, y, z, nx;
		longint unsigned m;
		bit flip;
		r = a % (2 * eart_pkg::HALF);
		flip = 1'b0;
		if (r >= eart_pkg::HALF) r -= 2 * eart_pkg::HALF;
		if (r < -eart_pkg::HALF) r += 2 * eart_pkg::HALF;
		if (r > eart_pkg::QUARTER) begin
			r = eart_pkg::HALF - r;
			flip = 1'b1;
		end else if (r < -eart_pkg::QUARTER) begin
			r = -eart_pkg::HALF - r;
			flip = 1'b1;
		end
		m = ((r < 0 ? -r : r) * longint'(eart_pkg::PI_Q30) + eart_pkg::HALF / 2)
			/ eart_pkg::HALF;
		rad = r < 0 ? -longint'(m) : longint'(m);
		x = eart_pkg::GAIN_Q30;
		y = 0;
		z = rad;
		for (int i = 0; i < 24; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= ATAN[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += ATAN[i];
			end
			x = nx;
		end
		s = y;
		c = flip ? -x : x;
	endfunction

	function automatic longint div_capped(input longint unsigned num, input bit neg,
			input longint den);
		longint unsigned q;
		if (den < 0) neg = !neg;
		if (den == 0) q = (num != 0) ? CAP : 0;
		else begin
			q = num / longint'(den < 0 ? -den : den);
			if (q > CAP) q = CAP;
		end
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [31:0] clip_rate(input longint v, inout logic sat);
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic rates_t euler_rates(input sample_t smp);
		rates_t res;
		longint sp, cp, sr, cr, ar, pr, hd, tr;
		longint wz, wy, wx;
		longint unsigned mag;
		wz = smp.wz;
		wy = smp.wy;
		wx = smp.wx;
		angle_sin_cos(smp.pitch, sp, cp);
		angle_sin_cos(smp.roll, sr, cr);
		ar = (wz * cr - wy * sr + (longint'(1) << 29)) >>> 30;
		pr = (wz * sr + wy * cr + (longint'(1) << 29)) >>> 30;
		mag = ar < 0 ? -ar : ar;
		hd = div_capped(mag << 30, ar < 0, cp);
		tr = div_capped(mag * longint'(sp < 0 ? -sp : sp), (ar < 0) != (sp < 0), cp);
		res.sat = 1'b0;
		res.heading = clip_rate(hd, res.sat);
		res.pitch = clip_rate(pr, res.sat);
		res.roll = clip_rate(wx - tr, res.sat);
		return res;
	endfunction

	task automatic send_sample(input sample_t smp);
		int gap;
		gap = ($urandom_range(0, 9) < 6) ? 0 :
			(($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3));
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {smp.roll, smp.pitch, smp.wx, smp.wy, smp.wz};
		do @(posedge clk); while (!s_tready);
		pending_rates.push_back(euler_rates(smp));
		samples_sent++;
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] rand_angle();
		case ($urandom_range(0, 3))
			0: return 16'(int'($urandom_range(0, 46080)) - 23040);
			1: return 16'(($urandom_range(0, 1) ? 11520 : -11520) +
				int'($urandom_range(0, 64)) - 32);
			2: return 16'(int'($urandom_range(0, 360)) * 128 - 23040);
			default: return 16'(int'($urandom_range(0, 2048)) - 1024);
		endcase
	endfunction

	function automatic logic signed [31:0] rand_rate();
		if ($urandom_range(0, 2) == 0) return $urandom;
		return 32'(int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
	endfunction

	task automatic send_one(input logic signed [31:0] wz, wy, wx,
			input logic signed [15:0] pitch, roll);
		sample_t smp;
		smp.wz = wz;
		smp.wy = wy;
		smp.wx = wx;
		smp.pitch = pitch;
		smp.roll = roll;
		send_sample(smp);
	endtask

	task automatic test_field_extremes();
		send_one(0, 0, 0, 0, 0);
		send_one(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 23040, 23040);
		send_one(32'sh80000000, 32'sh80000000, 32'sh80000000, -23040, -23040);
		send_one(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 0, -23040);
		send_one(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 23040, 0);
		send_one(32'sh0001_0000, 32'sh0001_0000, -32'sh0001_0000, 5760, -5760);
		send_one(-1, -1, -1, -1, -1);
		send_one(1, 1, 1, 1, 1);
	endtask

	task automatic test_vertical_pitch();
		send_one(32'sh0001_0000, 0, 32'sh0000_8000, 11520, 0);
		send_one(0, 0, 32'sh0000_8000, 11520, 0);
		send_one(0, 32'sh0002_0000, 0, -11520, 0);
		send_one(-32'sh0003_0000, 32'sh0001_0000, 0, 11520, 3000);
		send_one(32'sh0001_0000, 0, 0, 11519, 0);
		send_one(32'sh0001_0000, 0, 0, -11521, 0);
		send_one(32'sh7fffffff, 0, 0, 11400, 0);
	endtask

	task automatic test_angle_wrap();
		send_one(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 23040, -23040);
		send_one(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, -23040, 23040);
		send_one(32'sh0001_0000, -32'sh0002_0000, 0, 17280, -17280);
		send_one(32'sh0001_0000, -32'sh0002_0000, 0, -17280, 17280);
	endtask

	task automatic test_pitch_rate_overflow();
		send_one(32'sh7fffffff, 32'sh7fffffff, 0, 0, 5760);
		send_one(32'sh80000000, 32'sh80000000, 0, 0, 5760);
		send_one(32'sh80000000, 32'sh80000000, 0, 0, 5760);
	endtask

	task automatic test_random_samples(input int count);
		repeat (count) send_one(rand_rate(), rand_rate(), rand_rate(),
			rand_angle(), rand_angle());
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 199) == 0) rx_always_ready = !rx_always_ready;
			if (rx_always_ready) m_tready <= 1'b1;
			else if ($urandom_range(0, 29) == 0) m_tready <= 1'b0;
			else m_tready <= $urandom_range(0, 3) != 0;
		end
	end

	always @(posedge clk) begin
		rates_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_rates.size() == 0) begin
				errors++;
				$error("result transaction with no sample outstanding");
			end else begin
				want = pending_rates.pop_front();
				if (m_tdata[31:0] !== want.heading) begin
					errors++;
					$error("heading_rate: expected %0d, got %0d", want.heading,
						$signed(m_tdata[31:0]));
				end
				if (m_tdata[63:32] !== want.pitch) begin
					errors++;
					$error("pitch_rate: expected %0d, got %0d", want.pitch,
						$signed(m_tdata[63:32]));
				end
				if (m_tdata[95:64] !== want.roll) begin
					errors++;
					$error("roll_rate: expected %0d, got %0d", want.roll,
						$signed(m_tdata[95:64]));
				end
				if (m_tuser[0] !== want.sat) begin
					errors++;
					$error("saturated: expected %0d, got %0d", want.sat, m_tuser[0]);
				end
				if (want.sat) sat_seen++;
			end
		end
	end

	initial begin
		#20000000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int drain;
		errors = 0;
		samples_sent = 0;
		results_seen = 0;
		sat_seen = 0;
		rx_always_ready = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_field_extremes();
		test_vertical_pitch();
		test_angle_wrap();
		test_pitch_rate_overflow();
		test_random_samples(450);
		s_tvalid <= 1'b0;
		drain = 0;
		while (pending_rates.size() != 0 && drain < 200000) begin
			@(posedge clk);
			drain++;
		end
		repeat (150) @(posedge clk);
		if (pending_rates.size() != 0) begin
			errors++;
			$error("%0d results never arrived", pending_rates.size());
		end
		$display("Sent %0d attitude samples, checked %0d result transactions,",
			samples_sent, results_seen);
		$display("%0d of them saturated; %0d mismatches.", sat_seen, errors);
		if (errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/eart_pkg.sv
hw/rtl/eart_cordic.sv
hw/rtl/euler_angle_rate_transform.sv
tb/sv/tb.sv
